@@ rtl/core/jse_pkg.sv @@
// Shared types, character codes and helper functions of the JSON string escaper.
package jse_pkg;

    // Width of the running write position and of the capacity register
    localparam int POS_WIDTH = 16;
    localparam int CAP_WIDTH = 16;
    // Width that holds both position + 6 with its carry and the capacity
    localparam int CMP_WIDTH = (POS_WIDTH + 1 > CAP_WIDTH) ? POS_WIDTH + 1 : CAP_WIDTH;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    // Index of one output byte inside a job (at most six bytes)
    localparam int IDX_WIDTH = 3;

    // Character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_BSL     = 8'h5C;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_N   = 8'h6E;
    localparam logic [7:0] CH_LOW_R   = 8'h72;
    localparam logic [7:0] CH_LOW_T   = 8'h74;
    localparam logic [7:0] CH_LOW_U   = 8'h75;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    // Job kinds: plain byte, backslash pair, unicode escape, terminator
    typedef enum logic [1:0] {
        JK_CHAR,
        JK_PAIR,
        JK_UNI,
        JK_TERM
    } t_job_kind;

    // One queued job: the kind and its payload byte
    typedef struct packed {
        t_job_kind  kind;
        logic [7:0] data;
    } t_job;

    // Number of output bytes of a job
    function automatic logic [IDX_WIDTH-1:0] job_len(input t_job_kind kind);
        logic [IDX_WIDTH-1:0] len;
        unique case (kind)
            JK_CHAR: len = IDX_WIDTH'(1);
            JK_PAIR: len = IDX_WIDTH'(2);
            JK_UNI:  len = IDX_WIDTH'(6);
            JK_TERM: len = IDX_WIDTH'(1);
            default: len = IDX_WIDTH'(1);
        endcase
        return len;
    endfunction

    // Lower-case hex digit of a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = CH_ZERO + {4'd0, nib};
        end else begin
            ch = CH_LOW_A + {4'd0, nib} - 8'd10;
        end
        return ch;
    endfunction

    // Output byte number idx of a job
    function automatic logic [7:0] job_byte(input t_job job, input logic [IDX_WIDTH-1:0] idx);
        logic [7:0] ch;
        ch = CH_NUL;
        unique case (job.kind)
            JK_CHAR: ch = job.data;
            JK_PAIR: ch = (idx == '0) ? CH_BSL : job.data;
            JK_UNI: begin
                case (idx)
                    3'd0:    ch = CH_BSL;
                    3'd1:    ch = CH_LOW_U;
                    3'd2:    ch = CH_ZERO;
                    3'd3:    ch = CH_ZERO;
                    3'd4:    ch = hex_digit(job.data[7:4]);
                    default: ch = hex_digit(job.data[3:0]);
                endcase
            end
            JK_TERM: ch = CH_NUL;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

@@ rtl/core/jse_front.sv @@
// Front end: takes source bytes, tracks position and halt, classifies each byte into a job.
module jse_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [jse_pkg::CAP_WIDTH-1:0] i_cfg_wdata,
    input  logic                         i_src_valid,
    output logic                         o_src_ready,
    input  logic [7:0]                   i_src_byte,
    output logic                         o_push,
    output jse_pkg::t_job                o_push_job,
    input  logic                         i_queue_ready
);
    import jse_pkg::*;

    logic [CAP_WIDTH-1:0] r_capacity;
    logic [POS_WIDTH-1:0] r_position, n_position;
    logic                 r_halted, n_halted;

    logic                 accept;
    logic                 is_end;
    logic                 active;
    t_job_kind            kind;
    logic [7:0]           data;
    logic [CMP_WIDTH-1:0] end_sum;
    logic                 no_fit;

    assign o_src_ready = i_queue_ready;
    assign accept      = i_src_valid && o_src_ready;
    assign is_end      = (i_src_byte == CH_NUL);
    assign active      = (r_capacity != '0) && !r_halted;

    // Classify the source byte
    always_comb begin
        unique case (i_src_byte) inside
            CH_QUOTE, CH_BSL: begin
                kind = JK_PAIR;
                data = i_src_byte;
            end
            CH_LF: begin
                kind = JK_PAIR;
                data = CH_LOW_N;
            end
            CH_CR: begin
                kind = JK_PAIR;
                data = CH_LOW_R;
            end
            CH_TAB: begin
                kind = JK_PAIR;
                data = CH_LOW_T;
            end
            default: begin
                kind = (i_src_byte < CTRL_LIMIT) ? JK_UNI : JK_CHAR;
                data = i_src_byte;
            end
        endcase
    end

    // Check the item against capacity and the position range
    always_comb begin
        end_sum = CMP_WIDTH'(r_position) + CMP_WIDTH'(job_len(kind));
        no_fit  = (end_sum >= CMP_WIDTH'(r_capacity)) || end_sum[POS_WIDTH];
    end

    // Build the job and the next state
    always_comb begin
        o_push          = accept && active;
        o_push_job.kind = (is_end || no_fit) ? JK_TERM : kind;
        o_push_job.data = data;
        n_position      = r_position;
        n_halted        = r_halted;
        if (accept) begin
            if (is_end) begin
                n_position = '0;
                n_halted   = 1'b0;
            end else if (active) begin
                if (no_fit) begin
                    n_halted = 1'b1;
                end else begin
                    n_position = end_sum[POS_WIDTH-1:0];
                end
            end
        end
    end

    // Hold capacity and string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
            r_position <= '0;
            r_halted   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            r_position <= n_position;
            r_halted   <= n_halted;
        end
    end

endmodule

@@ rtl/core/jse_queue.sv @@
// Short job queue between front and back.
module jse_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jse_pkg::t_job i_push_job,
    output logic          o_ready,
    output logic          o_valid,
    output jse_pkg::t_job o_head,
    input  logic          i_pop
);
    import jse_pkg::*;

    t_job                  r_mem [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_WIDTH-1:0] r_count, n_count;
    logic                  do_push, do_pop;

    assign o_ready = (r_count != QCNT_WIDTH'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Track the fill level
    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Write the storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // Fill level never passes the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_WIDTH'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // No push arrives while the queue is full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("push while queue full");

    // A lone push raises the count by one
    a_count_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow push");

endmodule

@@ rtl/core/jse_back.sv @@
// Back end: expands each queued job into output bytes behind an output register.
module jse_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  jse_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_run_last,
    output logic          o_string_done
);
    import jse_pkg::*;

    logic                 r_valid;
    logic [7:0]           r_byte;
    logic                 r_last;
    logic                 r_done;
    logic [IDX_WIDTH-1:0] r_idx;

    logic                 load;
    logic                 is_last;
    logic [IDX_WIDTH-1:0] len;

    assign len     = job_len(i_job.kind);
    assign load    = i_job_valid && (!r_valid || i_out_ready);
    assign is_last = (r_idx == len - 1'b1);
    assign o_pop   = load && is_last;

    assign o_out_valid   = r_valid;
    assign o_out_byte    = r_byte;
    assign o_run_last    = r_last;
    assign o_string_done = r_done;

    // Load the next output word
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= job_byte(i_job, r_idx);
            r_last <= is_last;
            r_done <= (i_job.kind == JK_TERM);
        end
    end

    // Advance the byte index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? '0 : r_idx + 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Index rests at zero with no job waiting
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_job_valid |-> (r_idx == '0))
        else $error("byte index moved without a job");

    // Index stays inside the job
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> (r_idx < len))
        else $error("byte index past job length");

    // A terminator word always closes its run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_done) |-> (r_last && r_byte == CH_NUL))
        else $error("terminator word malformed");

endmodule

@@ rtl/core/json_string_escaper_top.sv @@
// Top level of the JSON string escaper: front end, job queue and back end.
//
// Channel   Direction  Handshake                      Word
// src       in         i_src_valid / o_src_ready      i_src_byte
// out       out        o_out_valid / i_out_ready      o_out_byte, o_run_last, o_string_done
// cfg       in         i_cfg_we (no wait)             i_cfg_wdata (capacity)
//
// A printable byte yields one output word; the back end emits one output word per cycle while i_out_ready is high.
// Escapes yield 2 or 6 output words; the queue lets the front keep taking bytes.
// An accepted byte is written into the queue; its first output word is then loaded into the output register.
// The source side stalls only while the four-entry queue is full.
// Reset is synchronous, active low, and clears capacity, position, halt and the queue.
module json_string_escaper_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [jse_pkg::CAP_WIDTH-1:0] i_cfg_wdata,
    input  logic                          i_src_valid,
    output logic                          o_src_ready,
    input  logic [7:0]                    i_src_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_out_byte,
    output logic                          o_run_last,
    output logic                          o_string_done
);
    import jse_pkg::*;

    logic push;
    t_job push_job;
    logic queue_ready;
    logic head_valid;
    t_job head_job;
    logic pop;

    jse_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_src_valid   (i_src_valid),
        .o_src_ready   (o_src_ready),
        .i_src_byte    (i_src_byte),
        .o_push        (push),
        .o_push_job    (push_job),
        .i_queue_ready (queue_ready)
    );

    jse_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_ready    (queue_ready),
        .o_valid    (head_valid),
        .o_head     (head_job),
        .i_pop      (pop)
    );

    jse_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (head_valid),
        .i_job         (head_job),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done)
    );

endmodule

@@ bench/json_string_escaper_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the JSON string escaper top level.
module json_string_escaper_top_tb;
    import jse_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 600;
    localparam int DIR_ROWS      = 26;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 30;

    // One output word: escaped byte with its flags
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       done;
    } t_esc_word;

    typedef enum logic {
        ROW_CFG,
        ROW_BYTE
    } t_row_kind;

    // Directed row: capacity write or source byte, with an optional typed-in result
    typedef struct packed {
        t_row_kind   kind;
        logic [15:0] val;
        logic        typed;
        logic        tcnt;
        t_esc_word   tword;
    } t_dir_row;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_we     = 1'b0;
    logic [CAP_WIDTH-1:0] i_cfg_wdata  = '0;
    logic                 i_src_valid  = 1'b0;
    logic [7:0]           i_src_byte   = '0;
    logic                 i_out_ready  = 1'b0;
    logic                 o_src_ready;
    logic                 o_out_valid;
    logic [7:0]           o_out_byte;
    logic                 o_run_last;
    logic                 o_string_done;

    // Escaper state as the bench sees it
    logic [CAP_WIDTH-1:0] cap_reg     = '0;
    logic [POS_WIDTH-1:0] wr_pos      = '0;
    logic                 halted_flag = 1'b0;

    t_esc_word step_words [6];
    int        step_cnt;
    t_esc_word pending_words [$];

    t_dir_row dir_tab [DIR_ROWS];
    int       mismatches  = 0;
    int       words_seen  = 0;
    int       idle_cycles = 0;
    bit       src_burst   = 1'b0;
    bit       out_burst   = 1'b0;
    int       stall_left  = 0;

    json_string_escaper_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_src_valid   (i_src_valid),
        .o_src_ready   (o_src_ready),
        .i_src_byte    (i_src_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [7:0] nibble_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return CH_ZERO + 8'(nib);
        end
        return CH_LOW_A + 8'(nib) - 8'd10;
    endfunction

    // Compute the words one source byte causes and advance the state
    task automatic escape_byte(input logic [7:0] b);
        logic [7:0] seq [6];
        int         len;
        longint     fin;
        int         i;
        step_cnt = 0;
        if (b == CH_NUL) begin
            if (cap_reg != 0 && !halted_flag) begin
                step_words[0] = '{CH_NUL, 1'b1, 1'b1};
                step_cnt = 1;
            end
            wr_pos = '0;
            halted_flag = 1'b0;
        end else if (cap_reg != 0 && !halted_flag) begin
            len = 2;
            seq[0] = CH_BSL;
            case (b)
                CH_QUOTE, CH_BSL: seq[1] = b;
                CH_LF:            seq[1] = CH_LOW_N;
                CH_CR:            seq[1] = CH_LOW_R;
                CH_TAB:           seq[1] = CH_LOW_T;
                default: begin
                    if (b < CTRL_LIMIT) begin
                        len = 6;
                        seq[1] = CH_LOW_U;
                        seq[2] = CH_ZERO;
                        seq[3] = CH_ZERO;
                        seq[4] = nibble_char(b[7:4]);
                        seq[5] = nibble_char(b[3:0]);
                    end else begin
                        len = 1;
                        seq[0] = b;
                    end
                end
            endcase
            fin = longint'(wr_pos) + len;
            // Item does not fit: terminate and ignore the rest of the string
            if (fin >= longint'(cap_reg) || fin > (longint'(1) << POS_WIDTH) - 1) begin
                step_words[0] = '{CH_NUL, 1'b1, 1'b1};
                step_cnt = 1;
                halted_flag = 1'b1;
            end else begin
                for (i = 0; i < len; i++) begin
                    step_words[i] = '{seq[i], (i == len - 1), 1'b0};
                end
                step_cnt = len;
                wr_pos = POS_WIDTH'(fin);
            end
        end
    endtask

    function automatic t_dir_row row_cfg(input logic [15:0] v);
        return '{ROW_CFG, v, 1'b0, 1'b0, '0};
    endfunction

    function automatic t_dir_row row_pred(input logic [7:0] b);
        return '{ROW_BYTE, {8'h00, b}, 1'b0, 1'b0, '0};
    endfunction

    function automatic t_dir_row row_none(input logic [7:0] b);
        return '{ROW_BYTE, {8'h00, b}, 1'b1, 1'b0, '0};
    endfunction

    function automatic t_dir_row row_one(input logic [7:0] b, input logic [7:0] ch,
                                         input logic last, input logic done);
        return '{ROW_BYTE, {8'h00, b}, 1'b1, 1'b1, t_esc_word'{ch, last, done}};
    endfunction

    // Mostly printable text, with escapes, control bytes and string ends mixed in
    function automatic logic [7:0] pick_byte();
        int         cls;
        logic [7:0] v;
        cls = $urandom_range(0, 99);
        if (cls < 8) begin
            v = CH_NUL;
        end else if (cls < 26) begin
            case ($urandom_range(0, 4))
                0:       v = CH_QUOTE;
                1:       v = CH_BSL;
                2:       v = CH_LF;
                3:       v = CH_CR;
                default: v = CH_TAB;
            endcase
        end else if (cls < 34) begin
            v = 8'($urandom_range(1, 31));
        end else if (cls < 44) begin
            v = 8'($urandom_range(0, 255));
        end else begin
            v = 8'($urandom_range(32, 255));
        end
        return v;
    endfunction

    // Drop valid and hold until every expected word has come, then let the pipe settle
    task automatic drain_words();
        i_src_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [15:0] v);
        drain_words();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cap_reg = v;
    endtask

    // Offer one source word after a random gap; predict it once accepted
    task automatic send_byte(input logic [7:0] b, input bit push_pred);
        int gap;
        int i;
        if ($urandom_range(0, 11) == 0) begin
            src_burst = !src_burst;
        end
        gap = src_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_src_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_src_valid <= 1'b1;
        i_src_byte  <= b;
        @(posedge i_clk);
        while (!o_src_ready) begin
            @(posedge i_clk);
        end
        escape_byte(b);
        if (push_pred) begin
            for (i = 0; i < step_cnt; i++) begin
                pending_words.push_back(step_words[i]);
            end
        end
    endtask

    task automatic note_mismatch(input string what, input t_esc_word want, input t_esc_word got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s at word %0d: expected byte %02h last %0b done %0b, got byte %02h last %0b done %0b",
                     what, words_seen, want.ch, want.last, want.done, got.ch, got.last, got.done);
        end
    endtask

    // Output side: random stall per word, with stretches of none
    always @(posedge i_clk) begin : out_pace
        int k;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else if (i_out_ready) begin
            if (o_out_valid) begin
                if ($urandom_range(0, 11) == 0) begin
                    out_burst <= !out_burst;
                end
                k = out_burst ? 0 : $urandom_range(0, 14);
                if (k != 0) begin
                    i_out_ready <= 1'b0;
                    stall_left  <= k;
                end
            end
        end else begin
            if (stall_left <= 1) begin
                i_out_ready <= 1'b1;
            end
            stall_left <= stall_left - 1;
        end
    end

    // Compare each accepted output word with the oldest expected one
    always @(posedge i_clk) begin : out_check
        t_esc_word got;
        t_esc_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_out_byte, o_run_last, o_string_done};
            if (pending_words.size() == 0) begin
                note_mismatch("unexpected word", '0, got);
            end else begin
                want = pending_words.pop_front();
                if (got.ch !== want.ch || got.last !== want.last || got.done !== want.done) begin
                    note_mismatch("mismatch", want, got);
                end
            end
            words_seen++;
        end
    end

    // Stop the run when neither side moves a word for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_src_valid && o_src_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("json_string_escaper_top regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        t_dir_row    row;
        int          ph;
        int          sent;
        int          i;
        logic [7:0]  b;
        logic [15:0] cap_v;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: capacity zero, every escape, overflow, halted string
        dir_tab = '{
            row_none(8'h41), row_none(CH_NUL),
            row_cfg(16'hFFFF),
            row_pred(8'h20), row_one(8'hFF, 8'hFF, 1'b1, 1'b0), row_pred(CH_QUOTE),
            row_pred(CH_BSL), row_pred(CH_LF), row_pred(CH_CR), row_pred(CH_TAB),
            row_pred(8'h01), row_pred(8'h1F), row_one(8'h7F, 8'h7F, 1'b1, 1'b0),
            row_one(CH_NUL, CH_NUL, 1'b1, 1'b1),
            row_cfg(16'd1),
            row_one(8'h41, CH_NUL, 1'b1, 1'b1), row_none(8'h42), row_none(CH_NUL),
            row_cfg(16'd4),
            row_pred(8'h61), row_pred(8'h62), row_one(CH_QUOTE, CH_NUL, 1'b1, 1'b1),
            row_none(CH_NUL),
            row_cfg(16'd7),
            row_pred(8'h1B), row_one(CH_NUL, CH_NUL, 1'b1, 1'b1)
        };
        for (i = 0; i < DIR_ROWS; i++) begin
            row = dir_tab[i];
            if (row.kind == ROW_CFG) begin
                set_capacity(row.val);
            end else begin
                send_byte(row.val[7:0], !row.typed);
                if (row.typed && row.tcnt) begin
                    pending_words.push_back(row.tword);
                end
            end
        end

        // Random part: phases of capacity, strings left open across the change
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       cap_v = 16'($urandom_range(8, 40));
                1:       cap_v = 16'hFFFF;
                2:       cap_v = 16'd0;
                3:       cap_v = 16'd2;
                4:       cap_v = 16'($urandom_range(0, 65535));
                5:       cap_v = 16'($urandom_range(3, 12));
                6:       cap_v = 16'($urandom_range(41, 300));
                default: cap_v = 16'd7;
            endcase
            set_capacity(cap_v);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 24) == 0) begin
                    drain_words();
                end
                b = pick_byte();
                send_byte(b, 1'b1);
                sent++;
            end
        end

        drain_words();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("json_string_escaper_top regression: pass");
        end else begin
            $display("json_string_escaper_top regression: fail");
        end
        $finish;
    end

endmodule
